@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Default screen geometry, stream field layout, character codes, item kinds,
// configuration register indexes and the controller state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int CELL_W   = 16;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Cell value that the screen holds after reset
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    // Color register reset values
    localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    // Configuration register indexes
    localparam logic CFG_FG_IDX = 1'b0;
    localparam logic CFG_BG_IDX = 1'b1;

    // Item kinds carried in tuser
    typedef enum logic [IN_TUSER_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } t_state;

endpackage

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram: screen cell memory
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen of ROWS x COLUMNS cells (color byte over character byte) in one
// memory, cursor tracking, wrap, newline, backspace, scroll, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Items come in on the s_axis channel (kind in tuser; character and read
//   position in tdata), and each item gives exactly one result on m_axis:
//   the read cell (zero for other kinds), the cursor after the item and a
//   scroll flag. The user is to set colors through the write port (index 0
//   foreground, index 1 background) only while the block is idle; the
//   block itself does not enforce this. The single write port of the screen
//   memory limits scroll and clear to one cell written per cycle. Scrolling
//   rotates a top-row pointer, so only the new bottom row is written.
//   After reset the block sweeps all ROWS*COLUMNS cells (2000 at the default
//   size) to blank with tready low; color writes are taken then.
//   A stalled receiver holds the result in the output register; the block
//   takes the next item meanwhile and holds its result until the slot frees.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [15:0] cell_entry, [20:16] cursor_row_out, [27:21] cursor_col_out,
    // [28] scrolled, [31:29] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [COLOR_W-1:0]     i_cfg_wdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    // Map a logical row and column to a memory address through the top pointer
    function automatic logic [AW-1:0] f_cell_addr(input logic [RW-1:0] lrow,
                                                  input logic [CW-1:0] col,
                                                  input logic [RW-1:0] top);
        logic [RW:0] sum;
        logic [RW:0] phys;
        sum  = {1'b0, lrow} + {1'b0, top};
        phys = (sum >= (RW+1)'(ROWS)) ? sum - (RW+1)'(ROWS) : sum;
        return AW'(phys * COLUMNS + col);
    endfunction

    // Registers
    t_state                  r_state, n_state;
    logic [RW-1:0]           r_row, n_row;
    logic [CW-1:0]           r_col, n_col;
    logic [RW-1:0]           r_top, n_top;
    logic [AW-1:0]           r_swp_addr, n_swp_addr;
    logic [CNTW-1:0]         r_swp_left, n_swp_left;
    logic [CELL_W-1:0]       r_swp_data, n_swp_data;
    logic [CELL_W-1:0]       r_res_cell, n_res_cell;
    logic                    r_res_scr, n_res_scr;
    logic                    r_rd_ok, n_rd_ok;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;
    logic [COLOR_W-1:0]      r_fg, r_bg;

    // Memory port signals
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [CELL_W-1:0]       ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [CELL_W-1:0]       ram_rdata;

    // Input fields
    logic [CHAR_W-1:0]       in_char;
    logic [RROW_W-1:0]       in_rrow;
    logic [RCOL_W-1:0]       in_rcol;
    logic                    accept;

    // Put path
    logic                    is_nl, is_bs, bs_at_zero;
    logic [CW-1:0]           wcol;
    logic [CW:0]             col_inc;
    logic [RW:0]             row_inc;
    logic                    wrap, row_adv, scroll;
    logic [RW-1:0]           top_inc;
    logic [CELL_W-1:0]       blank;

    // Read path
    logic [31:0]             rrow32, rcol32;
    logic                    rd_ok;

    // Result formatting
    logic [31:0]             row32, col32;

    assign in_char = i_s_axis_tdata[7:0];
    assign in_rrow = i_s_axis_tdata[12:8];
    assign in_rcol = i_s_axis_tdata[19:13];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Cursor arithmetic for a put
    assign is_nl      = (in_char == CH_NEWLINE);
    assign is_bs      = (in_char == CH_BACKSPACE);
    assign bs_at_zero = is_bs && (r_col == '0);
    assign wcol       = is_bs ? r_col - CW'(1) : r_col;
    assign col_inc    = {1'b0, r_col} + (CW+1)'(1);
    assign wrap       = !is_nl && !is_bs && (col_inc == (CW+1)'(COLUMNS));
    assign row_adv    = is_nl || wrap;
    assign row_inc    = {1'b0, r_row} + (RW+1)'(1);
    assign scroll     = row_adv && (row_inc == (RW+1)'(ROWS));
    assign top_inc    = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
    assign blank      = {r_bg, r_fg, CH_SPACE};

    // Read address and range check
    assign rrow32    = 32'(in_rrow);
    assign rcol32    = 32'(in_rcol);
    assign rd_ok     = (rrow32 < ROWS) && (rcol32 < COLUMNS);
    assign ram_raddr = f_cell_addr(rrow32[RW-1:0], rcol32[CW-1:0], r_top);

    // Cursor in result field widths
    assign row32 = 32'(r_row);
    assign col32 = 32'(r_col);

    // Next state, memory writes and result loading
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_swp_addr  = r_swp_addr;
        n_swp_left  = r_swp_left;
        n_swp_data  = r_swp_data;
        n_res_cell  = r_res_cell;
        n_res_scr   = r_res_scr;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_swp_addr;
        ram_wdata   = r_swp_data;

        // drop the result once the receiver takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_INIT, ST_SWEEP: begin
                // write one cell of the sweep per cycle
                ram_we     = 1'b1;
                n_swp_addr = r_swp_addr + AW'(1);
                n_swp_left = r_swp_left - CNTW'(1);
                if (r_swp_left == CNTW'(1)) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_res_cell = '0;
                    n_res_scr  = 1'b0;
                    n_state    = ST_DONE;
                    unique case (i_s_axis_tuser)
                        KIND_PUT: begin
                            // write the cell, then move the cursor
                            ram_we    = !is_nl && !bs_at_zero;
                            ram_waddr = f_cell_addr(r_row, wcol, r_top);
                            ram_wdata = {r_bg, r_fg, is_bs ? CH_SPACE : in_char};
                            if (row_adv) begin
                                n_col = '0;
                            end else if (is_bs) begin
                                n_col = bs_at_zero ? r_col : wcol;
                            end else begin
                                n_col = col_inc[CW-1:0];
                            end
                            if (scroll) begin
                                // old top row becomes the blank bottom row
                                n_row      = RW'(ROWS - 1);
                                n_top      = top_inc;
                                n_swp_addr = AW'(r_top * COLUMNS);
                                n_swp_left = CNTW'(COLUMNS);
                                n_swp_data = blank;
                                n_res_scr  = 1'b1;
                                n_state    = ST_SWEEP;
                            end else if (row_adv) begin
                                n_row = row_inc[RW-1:0];
                            end
                        end
                        KIND_CLEAR: begin
                            n_row      = '0;
                            n_col      = '0;
                            n_top      = '0;
                            n_swp_addr = '0;
                            n_swp_left = CNTW'(CELLS);
                            n_swp_data = blank;
                            n_state    = ST_SWEEP;
                        end
                        KIND_READ: begin
                            n_rd_ok = rd_ok;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // capture the cell read at the accept edge
                n_res_cell = r_rd_ok ? ram_rdata : '0;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // load the result once the output slot is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_res_scr, col32[RCOL_W-1:0],
                                   row32[RROW_W-1:0], r_res_cell};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_swp_addr  <= '0;
            r_swp_left  <= CNTW'(CELLS);
            r_swp_data  <= CELL_RESET;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_swp_addr  <= n_swp_addr;
            r_swp_left  <= n_swp_left;
            r_swp_data  <= n_swp_data;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res_cell <= n_res_cell;
        r_res_scr  <= n_res_scr;
        r_out_data <= n_out_data;
    end

    // Color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FG_IDX) begin
                r_fg <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_BG_IDX) begin
                r_bg <= i_cfg_wdata;
            end
        end
    end

    // Screen memory
    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console writer
// Feeds put, clear, read and unused-kind items over the input stream under
// changing colors and handshake pressure, predicts every result from a local
// screen image and cursor, and checks each output transfer field by field.
// ----------------------------------------------------------------------------
module testbench
    import tcw_pkg::*;
();

    localparam int COLS       = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int CELLS      = COLS * ROWS;
    localparam int HOLD_AT    = 580;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE_CYC = CELLS + 100;
    localparam logic [IN_TUSER_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [IN_TUSER_W-1:0] kind;
        logic [CHAR_W-1:0]     ch;
        logic [RROW_W-1:0]     rrow;
        logic [RCOL_W-1:0]     rcol;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0] entry;
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        logic              scrolled;
    } t_result;

    // DUT inputs, all known from time zero
    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [COLOR_W-1:0]     cfg_wdata = '0;

    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Stimulus and prediction state
    t_item   char_stream[$];
    t_result console_results[$];
    t_item   drv_item;
    t_result pred_res;
    t_result seen_res;
    t_result want_res;
    int      items_taken   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      errors        = 0;
    int      hold_left     = 0;
    logic    hold_done     = 1'b0;

    logic [CELL_W-1:0]  screen_img [0:CELLS-1];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    text_console_writer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [CELL_W-1:0] blank_cell();
        return {bg_color, fg_color, CH_SPACE};
    endfunction

    // Apply one item to the screen image and cursor, give its result
    task automatic apply_console_item(input t_item it, output t_result r);
        r = '0;
        case (it.kind)
            KIND_PUT: begin
                if (it.ch == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (it.ch == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_img[cur_row * COLS + cur_col] = blank_cell();
                    end
                end else begin
                    screen_img[cur_row * COLS + cur_col] = {bg_color, fg_color, it.ch};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // scroll up one row, blank the bottom row
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        screen_img[i] = screen_img[i + COLS];
                    for (int x = 0; x < COLS; x++)
                        screen_img[(ROWS - 1) * COLS + x] = blank_cell();
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_img[i] = blank_cell();
                cur_row = 0;
                cur_col = 0;
            end
            KIND_READ: begin
                if (it.rrow < ROWS && it.rcol < COLS)
                    r.entry = screen_img[it.rrow * COLS + it.rcol];
            end
            default: ;
        endcase
        r.row = cur_row[RROW_W-1:0];
        r.col = cur_col[RCOL_W-1:0];
    endtask

    task automatic report(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Driver: offer pending items, predict each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                apply_console_item(drv_item, pred_res);
                console_results.push_back(pred_res);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = char_stream.pop_front();
                    s_tdata  <= {4'b0, drv_item.rcol, drv_item.rrow, drv_item.ch};
                    s_tuser  <= drv_item.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once the stream is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                seen_res.entry    = o_m_axis_tdata[15:0];
                seen_res.row      = o_m_axis_tdata[20:16];
                seen_res.col      = o_m_axis_tdata[27:21];
                seen_res.scrolled = o_m_axis_tdata[28];
                if (console_results.size() == 0) begin
                    report($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    want_res = console_results.pop_front();
                    if (seen_res !== want_res)
                        report($sformatf(
                            "cell %h/%h row %0d/%0d col %0d/%0d scroll %0b/%0b (exp/got)",
                            want_res.entry, seen_res.entry, want_res.row, seen_res.row,
                            want_res.col, seen_res.col, want_res.scrolled,
                            seen_res.scrolled));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_item(input logic [IN_TUSER_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        t_item it;
        it.kind = kind;
        it.ch   = ch;
        it.rrow = rr;
        it.rcol = rc;
        char_stream.push_back(it);
    endtask

    // Mostly text with newline bursts to reach the bottom row, some noise
    task automatic add_random_items(input int n);
        int k;
        int roll;
        int run;
        logic [RROW_W-1:0] rr;
        logic [RCOL_W-1:0] rc;
        k = 0;
        while (k < n) begin
            roll = $urandom_range(99);
            rr   = RROW_W'($urandom);
            rc   = RCOL_W'($urandom);
            if (roll < 4) begin
                run = $urandom_range(30, 5);
                repeat (run) add_item(KIND_PUT, CH_NEWLINE, RROW_W'($urandom),
                                      RCOL_W'($urandom));
                k += run;
            end else begin
                if (roll < 60) begin
                    add_item(KIND_PUT, CHAR_W'($urandom_range(126, 32)), rr, rc);
                end else if (roll < 72) begin
                    add_item(KIND_PUT, CHAR_W'($urandom_range(255)), rr, rc);
                end else if (roll < 78) begin
                    add_item(KIND_PUT, CH_NEWLINE, rr, rc);
                end else if (roll < 83) begin
                    add_item(KIND_PUT, CH_BACKSPACE, rr, rc);
                end else if (roll < 95) begin
                    if ($urandom_range(9) < 8) begin
                        rr = RROW_W'($urandom_range(ROWS - 1));
                        rc = RCOL_W'($urandom_range(COLS - 1));
                    end
                    add_item(KIND_READ, CHAR_W'($urandom), rr, rc);
                end else if (roll < 97) begin
                    add_item(KIND_CLEAR, CHAR_W'($urandom), rr, rc);
                end else begin
                    add_item(KIND_UNUSED, CHAR_W'($urandom), rr, rc);
                end
                k++;
            end
        end
    endtask

    // Hold until every item is taken and every result has come back;
    // look at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (char_stream.size() != 0 || s_tvalid || console_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both colors on consecutive cycles while the block is idle
    task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FG_IDX;
        cfg_wdata <= fg;
        @(posedge i_clk);
        cfg_index <= CFG_BG_IDX;
        cfg_wdata <= bg;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        fg_color = fg;
        bg_color = bg;
        @(posedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = CELL_RESET;
        cur_row  = 0;
        cur_col  = 0;
        fg_color = FG_RESET;
        bg_color = BG_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing pass after reset
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);

        // phase 0: sender idles lightly, receiver heavily
        send_idle_pct = 29;
        recv_idle_pct = 78;
        write_colors(4'hF, 4'h0);

        // reset contents, corners and out-of-range reads
        add_item(KIND_READ, 8'h00, 5'd0, 7'd0);
        add_item(KIND_READ, 8'hFF, 5'd24, 7'd79);
        add_item(KIND_READ, 8'h00, 5'd25, 7'd0);
        add_item(KIND_READ, 8'h00, 5'd0, 7'd80);
        add_item(KIND_READ, 8'h00, 5'd31, 7'd127);
        // character extremes
        add_item(KIND_PUT, 8'h41, 5'd0, 7'd0);
        add_item(KIND_PUT, 8'h00, 5'd0, 7'd0);
        add_item(KIND_PUT, 8'hFF, 5'd31, 7'd127);
        add_item(KIND_PUT, 8'h80, 5'd0, 7'd0);
        add_item(KIND_READ, 8'h00, 5'd0, 7'd2);
        // backspace mid-row blanks the cell, at column zero does nothing
        add_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        add_item(KIND_READ, 8'h00, 5'd0, 7'd3);
        add_item(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0);
        add_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        add_item(KIND_UNUSED, 8'hFF, 5'd31, 7'd127);
        add_item(KIND_PUT, 8'h7F, 5'd0, 7'd0);
        // clear blanks with the current color and homes the cursor
        add_item(KIND_CLEAR, 8'hFF, 5'd31, 7'd127);
        add_item(KIND_READ, 8'h00, 5'd0, 7'd0);
        add_item(KIND_READ, 8'h00, 5'd24, 7'd79);
        add_item(KIND_PUT, CH_SPACE, 5'd0, 7'd0);
        add_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        add_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        add_item(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0);
        add_random_items(250);
        wait_idle();

        // phase 1: roles swapped
        send_idle_pct = 78;
        recv_idle_pct = 29;
        write_colors(4'h0, 4'hF);
        add_random_items(250);
        wait_idle();

        // phase 2: no idling, long receiver hold-off fills the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
        add_random_items(250);

        @(negedge i_clk);
        while (char_stream.size() != 0 || s_tvalid || console_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (console_results.size() != 0)
            report($sformatf("%0d results never arrived", console_results.size()));

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
